// ===== sv/imm_pkg.sv =====
package imm_pkg;

    // Storage geometry and element precision.
    localparam int MAX_DIM = 8;
    localparam int ELEM_W  = 16;

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MUL_W     = 2 * ELEM_W;

    // Fixed field widths of the stream payloads.
    localparam int ACT_W  = 2;
    localparam int ROW_W  = 3;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 35;
    localparam int DIM_W  = 4;

    localparam int IN_FIELDS_W  = 2 * ROW_W + VAL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * ROW_W + PROD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A,
        CFG_INNER_SIZE,
        CFG_COLS_B
    } t_imm_cfg_idx;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_A,
        ACT_WR_B,
        ACT_START,
        ACT_NONE
    } t_imm_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_imm_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              issue;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              first;
        logic              last_k;
        logic              last_elem;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_imm_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic busy;
        logic out_full;
        logic out_free;
    } t_imm_stat;

    // Row-major store address of an element.
    function automatic logic [ADDR_W-1:0] imm_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    // Highest index used for a dimension register; zero acts as one and
    // values past the storage size are clamped.
    function automatic logic [IDX_W-1:0] imm_last_idx(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            return '0;
        end else if (int'(d) > MAX_DIM) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return IDX_W'(d - 1'b1);
        end
    endfunction

endpackage

// ===== sv/imm_ctrl.sv =====
module imm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [imm_pkg::ACT_W-1:0]      i_action,
    input  logic [imm_pkg::DIM_W-1:0]      i_rows_a,
    input  logic [imm_pkg::DIM_W-1:0]      i_inner_size,
    input  logic [imm_pkg::DIM_W-1:0]      i_cols_b,
    input  imm_pkg::t_imm_stat             i_stat,
    output logic                           o_in_ready,
    output imm_pkg::t_imm_cmd              o_cmd
);
    import imm_pkg::*;

    t_imm_state       r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_done, n_done;

    logic [IDX_W-1:0] last_r;
    logic [IDX_W-1:0] last_k;
    logic [IDX_W-1:0] last_c;
    logic             in_accept;
    logic             start;

    assign last_r    = imm_last_idx(i_rows_a);
    assign last_k    = imm_last_idx(i_inner_size);
    assign last_c    = imm_last_idx(i_cols_b);
    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign start     = in_accept && (i_action == ACT_START);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_ISSUE: begin
                if (r_k == last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy && i_stat.out_free) begin
                    n_state = r_done ? ST_IDLE : ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_i    = r_i;
        n_j    = r_j;
        n_k    = r_k;
        n_done = r_done;
        if (start) begin
            n_i    = '0;
            n_j    = '0;
            n_k    = '0;
            n_done = 1'b0;
        end else if (r_state == ST_ISSUE) begin
            if (r_k == last_k) begin
                n_k = '0;
                if (r_j == last_c) begin
                    n_j = '0;
                    if (r_i == last_r) begin
                        n_done = 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd.wr_a      = in_accept && (i_action == ACT_WR_A);
        o_cmd.wr_b      = in_accept && (i_action == ACT_WR_B);
        o_cmd.issue     = (r_state == ST_ISSUE);
        o_cmd.a_addr    = imm_addr(r_i, r_k);
        o_cmd.b_addr    = imm_addr(r_k, r_j);
        o_cmd.first     = (r_k == '0);
        o_cmd.last_k    = (r_k == last_k);
        o_cmd.last_elem = (r_i == last_r) && (r_j == last_c);
        o_cmd.row       = r_i;
        o_cmd.col       = r_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_done  <= n_done;
        end
    end

    // The output register is always empty while dot-product terms are issued.
    a_issue_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> !i_stat.out_full)
        else $error("issuing while a result still waits");

    // The inner counter never runs past the inner dimension.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k <= last_k))
        else $error("inner counter out of range");

endmodule

// ===== sv/imm_datapath.sv =====
module imm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  imm_pkg::t_imm_cmd                 i_cmd,
    input  logic [imm_pkg::ROW_W-1:0]         i_row,
    input  logic [imm_pkg::ROW_W-1:0]         i_col,
    input  logic [imm_pkg::VAL_W-1:0]         i_value,
    input  logic                              i_m_ready,
    output imm_pkg::t_imm_stat                o_stat,
    output logic                              o_m_valid,
    output logic [imm_pkg::ROW_W-1:0]         o_out_row,
    output logic [imm_pkg::ROW_W-1:0]         o_out_col,
    output logic signed [imm_pkg::PROD_W-1:0] o_product,
    output logic                              o_last
);
    import imm_pkg::*;

    logic [ELEM_W-1:0] r_mem_a [MEM_DEPTH];
    logic [ELEM_W-1:0] r_mem_b [MEM_DEPTH];

    logic              wr_in_range;
    logic [ADDR_W-1:0] wr_addr;
    logic [ELEM_W-1:0] wr_data;

    // Stage 1: store read data.
    logic [ELEM_W-1:0] r_a_rd;
    logic [ELEM_W-1:0] r_b_rd;
    logic              r_s1_valid;
    logic              r_s1_first;
    logic              r_s1_last_k;
    logic              r_s1_last_elem;
    logic [IDX_W-1:0]  r_s1_row;
    logic [IDX_W-1:0]  r_s1_col;

    // Stage 2: registered product.
    logic signed [MUL_W-1:0] r_s2_prod;
    logic                    r_s2_valid;
    logic                    r_s2_first;
    logic                    r_s2_last_k;
    logic                    r_s2_last_elem;
    logic [IDX_W-1:0]        r_s2_row;
    logic [IDX_W-1:0]        r_s2_col;

    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] n_sum;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic signed [PROD_W-1:0] r_out_sum;
    logic                     r_out_last;

    assign wr_in_range = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
    assign wr_addr     = imm_addr(i_row[IDX_W-1:0], i_col[IDX_W-1:0]);
    assign wr_data     = ELEM_W'(i_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && wr_in_range) begin
            r_mem_a[wr_addr] <= wr_data;
        end
        r_a_rd <= r_mem_a[i_cmd.a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b && wr_in_range) begin
            r_mem_b[wr_addr] <= wr_data;
        end
        r_b_rd <= r_mem_b[i_cmd.b_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_first     <= i_cmd.first;
        r_s1_last_k    <= i_cmd.last_k;
        r_s1_last_elem <= i_cmd.last_elem;
        r_s1_row       <= i_cmd.row;
        r_s1_col       <= i_cmd.col;
        r_s2_prod      <= signed'(r_a_rd) * signed'(r_b_rd);
        r_s2_first     <= r_s1_first;
        r_s2_last_k    <= r_s1_last_k;
        r_s2_last_elem <= r_s1_last_elem;
        r_s2_row       <= r_s1_row;
        r_s2_col       <= r_s1_col;
        if (r_s2_valid) begin
            r_acc <= n_sum;
        end
        if (r_s2_valid && r_s2_last_k) begin
            r_out_row  <= r_s2_row;
            r_out_col  <= r_s2_col;
            r_out_sum  <= n_sum;
            r_out_last <= r_s2_last_elem;
        end
    end

    // The sum wraps to the result width.
    always_comb begin
        if (r_s2_first) begin
            n_sum = PROD_W'(r_s2_prod);
        end else begin
            n_sum = r_acc + PROD_W'(r_s2_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid && r_s2_last_k) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.busy     = r_s1_valid || r_s2_valid;
    assign o_stat.out_full = r_out_valid;
    assign o_stat.out_free = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_out_row = ROW_W'(r_out_row);
    assign o_out_col = ROW_W'(r_out_col);
    assign o_product = r_out_sum;
    assign o_last    = r_out_last;

    // A finished sum only lands in an output register that is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_last_k) |-> o_stat.out_free)
        else $error("result overwrote a pending result");

    // Store writes never coincide with a product run in flight.
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_a || i_cmd.wr_b) |-> !(i_cmd.issue || o_stat.busy))
        else $error("store written during a product run");

    // Terms of one dot product arrive back to back.
    a_acc_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_first) |-> $past(r_s2_valid))
        else $error("gap inside a dot product");

endmodule

// ===== sv/integer_matrix_multiply.sv =====
// A write transfer is registered straight into its store. Input transfers for writes
// are taken one per cycle while the block is idle; none are taken during a product run.
// Product elements are computed one at a time by the single multiply-accumulate unit
// (one term a cycle); each element waits for an empty pipeline and a free output.
// Reset (i_rst_n, synchronous, active low) clears control state and sets all three
// dimension registers to 8; the matrix stores hold no defined value until written.
module integer_matrix_multiply (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [imm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: row_index [2:0], col_index [5:3], element_value [21:6], zero pad above.
    input  logic [imm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tuser: action [1:0].
    input  logic [imm_pkg::ACT_W-1:0]            s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: out_row [2:0], out_col [5:3], product_value [40:6], zero pad above.
    output logic [imm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import imm_pkg::*;

    // Dimension registers keep the written bits; the controller clamps them when used.
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner_size;
    logic [DIM_W-1:0] r_cols_b;

    t_imm_cmd  cmd;
    t_imm_stat stat;

    logic [ROW_W-1:0]         in_row;
    logic [ROW_W-1:0]         in_col;
    logic [VAL_W-1:0]         in_value;
    logic [ROW_W-1:0]         out_row;
    logic [ROW_W-1:0]         out_col;
    logic signed [PROD_W-1:0] out_product;

    // Unpack the input payload, lowest field first.
    assign in_row   = s_axis_tdata[ROW_W-1:0];
    assign in_col   = s_axis_tdata[2*ROW_W-1:ROW_W];
    assign in_value = s_axis_tdata[IN_FIELDS_W-1:2*ROW_W];

    // Configuration writes must come only while the block is idle (not enforced
    // here); registers feed the controller directly. An unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= DIM_RESET;
            r_inner_size <= DIM_RESET;
            r_cols_b     <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (t_imm_cfg_idx'(i_cfg_index))
                CFG_ROWS_A:     r_rows_a     <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_B:     r_cols_b     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The controller walks row, column and inner index of the product and
    // holds off input transfers for the whole run.
    imm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_action     (s_axis_tuser),
        .i_rows_a     (r_rows_a),
        .i_inner_size (r_inner_size),
        .i_cols_b     (r_cols_b),
        .i_stat       (stat),
        .o_in_ready   (s_axis_tready),
        .o_cmd        (cmd)
    );

    // The datapath holds both stores, the multiply-accumulate pipeline and
    // the output register, which lets a finished result wait for the sink.
    imm_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_row     (in_row),
        .i_col     (in_col),
        .i_value   (in_value),
        .i_m_ready (m_axis_tready),
        .o_stat    (stat),
        .o_m_valid (m_axis_tvalid),
        .o_out_row (out_row),
        .o_out_col (out_col),
        .o_product (out_product),
        .o_last    (m_axis_tlast)
    );

    // Pack the result payload, lowest field first.
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_product, out_col, out_row};

endmodule

// ===== sim/tb_integer_matrix_multiply.sv =====
`timescale 1ns / 1ps

// Checks the integer matrix multiply against its own model of the product.
// Element writes load a private copy of both stores. Each start transfer
// queues the expected product elements in row-major order, and the output
// monitor checks every output transfer against the oldest queued element.
module tb_integer_matrix_multiply;
    import imm_pkg::*;

    // The index that no register answers to. Writes to it must leave all
    // three dimensions as they were.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = '1;

    // Bit positions of the fields in the output tdata.
    localparam int COL_LSB  = ROW_W;
    localparam int PROD_LSB = 2 * ROW_W;

    // Store entries are coded as one number: A entries come first and B
    // entries are offset by the depth of one store.
    localparam int ENTRY_B_BASE = MEM_DEPTH;

    // Up to this many needed entries, a product set rewrites all of them.
    // Larger sets rewrite only a random part, since the rest stays valid.
    localparam int DENSE_LIMIT = 24;

    // The directed tests send about 160 items; the random phases fill up the
    // rest of the run.
    localparam int RANDOM_ITEMS = 210;

    // Quiet cycles after every queued product element has come out, before the
    // dimensions change and before the run ends, so that the last write has landed.
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;

    // The longest stretch without any transfer in a correct run is one
    // product element plus the longest receiver stall, a sender gap and a
    // settle pause, and the limit leaves a wide margin over that.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         col;
        logic signed [PROD_W-1:0] value;
        logic                     is_last;
    } t_product;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: row_index [2:0], col_index [5:3], element_value [21:6], zero pad above.
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: action [1:0].
    logic [ACT_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: out_row [2:0], out_col [5:3], product_value [40:6], zero pad above.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // Model state: both stores, which entries hold a value, and the three
    // dimension registers as written.
    logic signed [VAL_W-1:0] store_a [MEM_DEPTH];
    logic signed [VAL_W-1:0] store_b [MEM_DEPTH];
    bit                      a_written [MEM_DEPTH];
    bit                      b_written [MEM_DEPTH];
    logic [DIM_W-1:0]        dim_rows  = DIM_RESET;
    logic [DIM_W-1:0]        dim_inner = DIM_RESET;
    logic [DIM_W-1:0]        dim_cols  = DIM_RESET;

    t_product pending_products [$];
    int       mismatch_count = 0;
    int       accepted_items = 0;

    // Sender pacing: bursts of random length with random gaps between them.
    bit gaps_on    = 1'b0;
    int burst_left = 0;
    bit bus_held   = 1'b0;

    // Receiver pacing.
    int rx_mode = 0;
    int rx_left = 0;

    int quiet_cycles = 0;

    integer_matrix_multiply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A register value of zero acts as one and anything past the store size
    // acts as the store size.
    function automatic int active_dim(input logic [DIM_W-1:0] reg_val);
        if (reg_val == '0) begin
            return 1;
        end
        if (int'(reg_val) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(reg_val);
    endfunction

    // Element values lean toward the extremes now and then.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(VAL_W-1){1'b0}}};
            1: return {1'b0, {(VAL_W-1){1'b1}}};
            2: return '1;
            3: return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Mostly small dimensions keep the product sets short; zero and values
    // past the store size show up too.
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
            2, 3: return DIM_W'($urandom_range(5, MAX_DIM));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Computes every element of the product from the model stores and queues
    // it, in the row-major order the block emits them.
    task automatic predict_products();
        t_product item;
        longint   acc;
        int       nr;
        int       nk;
        int       nc;
        nr = active_dim(dim_rows);
        nk = active_dim(dim_inner);
        nc = active_dim(dim_cols);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = 0;
                for (int k = 0; k < nk; k++) begin
                    acc += longint'(store_a[i * MAX_DIM + k]) *
                           longint'(store_b[k * MAX_DIM + j]);
                end
                item.row     = ROW_W'(i);
                item.col     = ROW_W'(j);
                item.value   = PROD_W'(acc);
                item.is_last = (i == nr - 1) && (j == nc - 1);
                pending_products.push_back(item);
            end
        end
    endtask

    // Sends one item and waits for its transfer. The valid stays high after
    // the transfer so that a following item goes out without a bubble;
    // release_bus lowers it when the sender stops.
    task automatic send_item(input t_imm_action act, input logic [ROW_W-1:0] row,
                             input logic [ROW_W-1:0] col,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (bus_held) begin
                s_axis_tvalid <= 1'b0;
                bus_held = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({val, col, row});
        s_axis_tuser  <= act;
        bus_held = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);

        // The transfer took place at this edge; bring the model along.
        case (act)
            ACT_WR_A: begin
                store_a[row * MAX_DIM + col]   = val;
                a_written[row * MAX_DIM + col] = 1'b1;
            end
            ACT_WR_B: begin
                store_b[row * MAX_DIM + col]   = val;
                b_written[row * MAX_DIM + col] = 1'b1;
            end
            ACT_START: begin
                predict_products();
            end
            default: begin
            end
        endcase
        if (act != ACT_NONE) begin
            accepted_items++;
        end
    endtask

    task automatic release_bus();
        if (bus_held) begin
            s_axis_tvalid <= 1'b0;
            bus_held = 1'b0;
        end
    endtask

    // The sender holds off until every queued product element has come out,
    // then lets the block settle.
    task automatic wait_drained();
        release_bus();
        while (pending_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable stays high for back-to-back writes; cfg_release lowers
    // it after the last one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ROWS_A:     dim_rows  = val;
            CFG_INNER_SIZE: dim_inner = val;
            CFG_COLS_B:     dim_cols  = val;
            default: begin
            end
        endcase
    endtask

    task automatic cfg_release();
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_entry(input int code, input logic signed [VAL_W-1:0] val);
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        row = ROW_W'((code % MEM_DEPTH) / MAX_DIM);
        col = ROW_W'(code % MAX_DIM);
        if (code >= ENTRY_B_BASE) begin
            send_item(ACT_WR_B, row, col, val);
        end else begin
            send_item(ACT_WR_A, row, col, val);
        end
    endtask

    task automatic shuffle_entries(ref int entries[$]);
        int pick;
        int held;
        for (int n = entries.size() - 1; n > 0; n--) begin
            pick          = $urandom_range(0, n);
            held          = entries[n];
            entries[n]    = entries[pick];
            entries[pick] = held;
        end
    endtask

    // Noise between the well-formed writes: the unused action, or a write
    // anywhere in either store, inside or outside the current dimensions.
    task automatic send_noise();
        if ($urandom_range(0, 2) == 0) begin
            send_item(ACT_NONE, ROW_W'($urandom), ROW_W'($urandom), VAL_W'($urandom));
        end else begin
            write_entry($urandom_range(0, 2 * MEM_DEPTH - 1), pick_value());
        end
    endtask

    // Loads the entries the current dimensions read, in random order, then
    // starts the product. Entries never written are always loaded, so a
    // start never reads an undefined entry. A broken set skips about half
    // of the entries that already hold a value.
    task automatic send_product_set(input bit broken);
        int entries [$];
        int nr;
        int nk;
        int nc;
        int code;
        bit written;
        bit do_write;
        nr = active_dim(dim_rows);
        nk = active_dim(dim_inner);
        nc = active_dim(dim_cols);
        for (int i = 0; i < nr; i++) begin
            for (int k = 0; k < nk; k++) begin
                entries.push_back(i * MAX_DIM + k);
            end
        end
        for (int k = 0; k < nk; k++) begin
            for (int j = 0; j < nc; j++) begin
                entries.push_back(ENTRY_B_BASE + k * MAX_DIM + j);
            end
        end
        shuffle_entries(entries);
        foreach (entries[n]) begin
            if ($urandom_range(0, 7) == 0) begin
                send_noise();
            end
            code = entries[n];
            if (code >= ENTRY_B_BASE) begin
                written = b_written[code - ENTRY_B_BASE];
            end else begin
                written = a_written[code];
            end
            if (!written) begin
                do_write = 1'b1;
            end else if (broken) begin
                do_write = ($urandom_range(0, 1) == 1);
            end else if (entries.size() <= DENSE_LIMIT) begin
                do_write = 1'b1;
            end else begin
                do_write = ($urandom_range(0, 3) == 0);
            end
            if (do_write) begin
                write_entry(code, pick_value());
            end
        end
        // The block ignores the data fields of a start, so they carry noise.
        send_item(ACT_START, ROW_W'($urandom), ROW_W'($urandom), VAL_W'($urandom));
    endtask

    // Reset leaves inner_size at eight. With one row and one column, the
    // single product element is eight times the square of the most negative
    // element, the largest magnitude the product field ever carries.
    task automatic test_reset_dims();
        cfg_write(CFG_ROWS_A, DIM_W'(1));
        cfg_write(CFG_COLS_B, DIM_W'(1));
        cfg_release();
        for (int k = 0; k < MAX_DIM; k++) begin
            send_item(ACT_WR_A, '0, ROW_W'(k), {1'b1, {(VAL_W-1){1'b0}}});
            send_item(ACT_WR_B, ROW_W'(k), '0, {1'b1, {(VAL_W-1){1'b0}}});
        end
        send_item(ACT_START, '0, '0, '0);
        wait_drained();
    endtask

    // Zero dimensions act as one and a dimension past the store size acts as
    // the store size. A write to the unused register index must change
    // nothing, and the unused action must be dropped.
    task automatic test_dim_clamp();
        logic signed [VAL_W-1:0] b_row [MAX_DIM] = '{
            16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000,
            16'sh0001, 16'sh5555, 16'shAAAA, 16'sh3039
        };
        cfg_write(CFG_ROWS_A, '0);
        cfg_write(CFG_INNER_SIZE, '0);
        cfg_write(CFG_COLS_B, '1);
        cfg_write(CFG_SPARE_IDX, DIM_W'(2));
        cfg_release();
        send_item(ACT_WR_A, '0, '0, {1'b0, {(VAL_W-1){1'b1}}});
        for (int j = 0; j < MAX_DIM; j++) begin
            send_item(ACT_WR_B, '0, ROW_W'(j), b_row[j]);
        end
        send_item(ACT_NONE, '1, '1, '1);
        // Outside the current dimensions; stored but not read by this product.
        send_item(ACT_WR_A, ROW_W'(5), ROW_W'(6), 16'sh1234);
        send_item(ACT_START, '0, '0, '0);
        wait_drained();
    endtask

    // Full stores, every row and column index in use, and the largest result
    // count. The second start follows the first at once and must give the
    // same elements again.
    task automatic test_full_size();
        int entries [$];
        cfg_write(CFG_ROWS_A, DIM_W'(MAX_DIM + 1));
        cfg_write(CFG_INNER_SIZE, DIM_W'(MAX_DIM));
        cfg_write(CFG_COLS_B, DIM_W'(MAX_DIM));
        cfg_release();
        gaps_on = 1'b1;
        for (int n = 0; n < 2 * MEM_DEPTH; n++) begin
            entries.push_back(n);
        end
        shuffle_entries(entries);
        foreach (entries[n]) begin
            write_entry(entries[n], pick_value());
        end
        send_item(ACT_START, '0, '0, '0);
        send_item(ACT_START, '1, '1, '1);
        wait_drained();
    endtask

    // Phases of random dimensions, each with one to three product sets. The
    // sender sometimes drains the block between sets.
    task automatic test_random_sequences();
        int first_count;
        int sets;
        first_count = accepted_items;
        while (accepted_items - first_count < RANDOM_ITEMS) begin
            wait_drained();
            cfg_write(CFG_ROWS_A, pick_dim());
            cfg_write(CFG_INNER_SIZE, pick_dim());
            cfg_write(CFG_COLS_B, pick_dim());
            if ($urandom_range(0, 4) == 0) begin
                cfg_write(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
            end
            cfg_release();
            gaps_on = ($urandom_range(0, 3) != 0);
            sets    = $urandom_range(1, 3);
            repeat (sets) begin
                send_product_set($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 3) == 0) begin
                    wait_drained();
                end
            end
        end
    endtask

    // Receiver stall pattern: each time a countdown of random length runs out,
    // the mode is redrawn among always ready, ready half the time, and rarely
    // ready.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(30, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every output transfer is held against the oldest queued element.
    always @(posedge i_clk) begin : product_checker
        t_product want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_products.size() == 0) begin
                $display("%0t: product element with none expected, row %0d col %0d value %0d",
                         $time, m_axis_tdata[ROW_W-1:0], m_axis_tdata[COL_LSB +: ROW_W],
                         $signed(m_axis_tdata[PROD_LSB +: PROD_W]));
                mismatch_count++;
            end else begin
                want = pending_products.pop_front();
                check_field("out_row", want.row, m_axis_tdata[ROW_W-1:0]);
                check_field("out_col", want.col, m_axis_tdata[COL_LSB +: ROW_W]);
                check_field("product_value", want.value,
                            $signed(m_axis_tdata[PROD_LSB +: PROD_W]));
                check_field("last", want.is_last, m_axis_tlast);
            end
        end
    end

    // Ends a hung run: counts cycles in which no transfer happens on
    // either stream.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_matrix_multiply test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_dims();
        test_dim_clamp();
        test_full_size();
        test_random_sequences();

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (pending_products.size() != 0) begin
            $display("%0t: %0d product elements never arrived", $time,
                     pending_products.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("integer_matrix_multiply test passed");
        end else begin
            $display("integer_matrix_multiply test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/imm_pkg.sv
sv/imm_ctrl.sv
sv/imm_datapath.sv
sv/integer_matrix_multiply.sv
sim/tb_integer_matrix_multiply.sv
